@@ rtl/core/sdo_pkg.sv @@
// Package for the spectral difference onset block: sizes, configuration codes
// and the types shared by the front end, the queue, the back end and the top level.
// Depends on nothing.
package sdo_pkg;

  // Frame geometry and the history ring.
  localparam int NUM_BINS   = 1024;
  localparam int MAX_STEP   = 4;
  localparam int HIST_DEPTH = NUM_BINS * MAX_STEP;
  localparam int ADDR_W     = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int POS_W      = $clog2(NUM_BINS + 1);
  localparam int CNT_W      = $clog2(MAX_STEP + 1);
  localparam int SLOT_W     = (MAX_STEP > 1) ? $clog2(MAX_STEP) : 1;

  // Data widths.
  localparam int MAG_W  = 16;
  localparam int DIFF_W = 2 * MAG_W;
  localparam int SUM_W  = 48;

  // Queue between the front end and the back end.
  localparam int QUEUE_DEPTH = 4;
  localparam int QLEVEL_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_FRAMES   = 2'd0,
    REG_POSITIVE_ONLY = 2'd1,
    REG_SQUARE_MODE   = 2'd2
  } cfg_reg_t;

  // Configuration register contents.
  typedef struct packed {
    logic [2:0] step_frames;
    logic       positive_only;
    logic       square_mode;
  } cfg_t;

  // One classified bin on its way from the front end to the back end.
  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic [MAG_W-1:0] prev;
    logic             use_bin;
    logic             warm;
    logic             last;
    logic             fresh;
  } entry_t;

endpackage

@@ rtl/core/sdo_queue.sv @@
// Short first-in first-out queue of classified bins between front and back end.
// Depends on sdo_pkg.
module sdo_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  sdo_pkg::entry_t         push_entry,
  input  logic                    pop,
  output sdo_pkg::entry_t         head_entry,
  output logic                    empty,
  output logic [sdo_pkg::QLEVEL_W-1:0] level
);
  import sdo_pkg::*;

  entry_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic              do_pop;

  assign empty      = (level == '0);
  assign do_pop     = pop && !empty;
  assign head_entry = slots[rd_ptr];

  // Pointer and fill level bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, do_pop})
        2'b10:   level <= level + 1'b1;
        2'b01:   level <= level - 1'b1;
        default: level <= level;
      endcase
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

@@ rtl/core/sdo_front.sv @@
// Front end: accepts bins, tracks frame position and history slot, reads and
// writes the frame history memory and hands classified bins to the queue.
// Depends on sdo_pkg.
module sdo_front (
  input  logic                         clk,
  input  logic                         rst,
  input  sdo_pkg::cfg_t                cfg,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [sdo_pkg::MAG_W-1:0]    magnitude,
  input  logic                         include_req,
  input  logic                         last_bin,
  input  logic                         new_sequence,
  input  logic [sdo_pkg::QLEVEL_W-1:0] queue_level,
  output logic                         push,
  output sdo_pkg::entry_t              push_entry
);
  import sdo_pkg::*;

  localparam int OS_W = CNT_W + 1;

  // Frame tracking state.
  logic [POS_W-1:0]  bin_position;
  logic [CNT_W-1:0]  frames_seen;
  logic [SLOT_W-1:0] frame_slot;

  // History memory and its registered read port.
  logic [MAG_W-1:0]  frame_history [HIST_DEPTH];
  logic [MAG_W-1:0]  prev_data;

  // Stage register holding the bin whose history read is in flight.
  logic              s1_valid;
  logic [MAG_W-1:0]  s1_mag;
  logic              s1_use;
  logic              s1_warm;
  logic              s1_last;
  logic              s1_fresh;

  logic              accept;
  logic [7:0]        step_ext;
  logic [7:0]        step_eff8;
  logic [CNT_W-1:0]  step;
  logic [POS_W-1:0]  pos_cur;
  logic [CNT_W-1:0]  seen_cur;
  logic [SLOT_W-1:0] slot_cur;
  logic              warm;
  logic              in_range;
  logic [OS_W-1:0]   old_sum;
  logic [SLOT_W-1:0] old_slot;
  logic [ADDR_W-1:0] old_addr;
  logic [ADDR_W-1:0] new_addr;

  // Hold off new bins unless the queue can take every bin already in flight.
  assign in_stall = (QLEVEL_W'(32'(queue_level) + 32'(s1_valid)) >= QLEVEL_W'(QUEUE_DEPTH));
  assign accept   = in_valid && !in_stall;

  // Effective frame distance, clamped to one through the ring depth.
  always_comb begin
    step_ext = {5'd0, cfg.step_frames};
    if (step_ext == 8'd0) begin
      step_eff8 = 8'd1;
    end else if (step_ext > 8'(MAX_STEP)) begin
      step_eff8 = 8'(MAX_STEP);
    end else begin
      step_eff8 = step_ext;
    end
    step = CNT_W'(step_eff8);
  end

  // A new sequence restarts position, frame count and slot before the bin is used.
  always_comb begin
    pos_cur  = new_sequence ? '0 : bin_position;
    seen_cur = new_sequence ? '0 : frames_seen;
    slot_cur = new_sequence ? '0 : frame_slot;
    warm     = (seen_cur < step);
    in_range = (pos_cur < POS_W'(NUM_BINS));
  end

  // History addresses: the slot step frames back and the current slot.
  always_comb begin
    old_sum  = OS_W'(slot_cur) + OS_W'(MAX_STEP) - OS_W'(step);
    old_slot = (old_sum >= OS_W'(MAX_STEP)) ? SLOT_W'(old_sum - OS_W'(MAX_STEP))
                                            : SLOT_W'(old_sum);
    old_addr = ADDR_W'(ADDR_W'(old_slot) * ADDR_W'(NUM_BINS)) + ADDR_W'(pos_cur);
    new_addr = ADDR_W'(ADDR_W'(slot_cur) * ADDR_W'(NUM_BINS)) + ADDR_W'(pos_cur);
  end

  // Frame tracking update on each accepted bin.
  always_ff @(posedge clk) begin
    if (rst) begin
      bin_position <= '0;
      frames_seen  <= '0;
      frame_slot   <= '0;
    end else if (accept) begin
      if (last_bin) begin
        bin_position <= '0;
        frame_slot   <= (slot_cur == SLOT_W'(MAX_STEP - 1)) ? '0 : slot_cur + 1'b1;
        frames_seen  <= (seen_cur < CNT_W'(MAX_STEP)) ? seen_cur + 1'b1 : seen_cur;
      end else begin
        bin_position <= in_range ? pos_cur + 1'b1 : pos_cur;
        frame_slot   <= slot_cur;
        frames_seen  <= seen_cur;
      end
    end
  end

  // History memory: the old entry is read before the new magnitude lands.
  always_ff @(posedge clk) begin
    if (accept) begin
      prev_data <= frame_history[old_addr];
      if (in_range) begin
        frame_history[new_addr] <= magnitude;
      end
    end
  end

  // Stage register alongside the memory read.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mag   <= magnitude;
      s1_use   <= include_req && !warm && in_range;
      s1_warm  <= warm;
      s1_last  <= last_bin;
      s1_fresh <= new_sequence;
    end
  end

  // The queue always has room for this bin, so it goes in unconditionally.
  assign push                = s1_valid;
  assign push_entry.mag      = s1_mag;
  assign push_entry.prev     = prev_data;
  assign push_entry.use_bin  = s1_use;
  assign push_entry.warm     = s1_warm;
  assign push_entry.last     = s1_last;
  assign push_entry.fresh    = s1_fresh;

endmodule

@@ rtl/core/sdo_back.sv @@
// Back end: forms the per-bin difference or its square, accumulates the frame
// sum with saturation and holds the result for the output channel.
// Depends on sdo_pkg.
module sdo_back (
  input  logic                      clk,
  input  logic                      rst,
  input  sdo_pkg::cfg_t             cfg,
  input  sdo_pkg::entry_t           head_entry,
  input  logic                      empty,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [sdo_pkg::SUM_W-1:0] flux_value,
  output logic                      warming_up,
  output logic                      saturated
);
  import sdo_pkg::*;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  // Difference stage.
  logic              b1_valid;
  logic [DIFF_W-1:0] b1_diff;
  logic              b1_warm;
  logic              b1_last;
  logic              b1_fresh;

  // Frame accumulator.
  logic [SUM_W-1:0]  frame_sum;
  logic              sum_clipped;

  logic              advance;
  logic [MAG_W-1:0]  diff_mag;
  logic [DIFF_W-1:0] diff_term;
  logic [SUM_W-1:0]  sum_base;
  logic              clip_base;
  logic [SUM_W:0]    sum_wide;
  logic [SUM_W-1:0]  sum_new;
  logic              clip_new;

  // The whole back end moves unless a finished result is waiting to be taken.
  assign advance = !(out_valid && out_stall);
  assign pop     = advance && !empty;

  // Rectified or absolute difference, then optionally squared.
  always_comb begin
    if (head_entry.mag >= head_entry.prev) begin
      diff_mag = head_entry.mag - head_entry.prev;
    end else if (cfg.positive_only) begin
      diff_mag = '0;
    end else begin
      diff_mag = head_entry.prev - head_entry.mag;
    end
    if (!head_entry.use_bin) begin
      diff_term = '0;
    end else if (cfg.square_mode) begin
      diff_term = DIFF_W'(diff_mag) * DIFF_W'(diff_mag);
    end else begin
      diff_term = DIFF_W'(diff_mag);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
    end else if (advance) begin
      b1_valid <= !empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b1_diff  <= diff_term;
      b1_warm  <= head_entry.warm;
      b1_last  <= head_entry.last;
      b1_fresh <= head_entry.fresh;
    end
  end

  // Saturating accumulate; a new sequence starts from an empty sum.
  always_comb begin
    sum_base  = b1_fresh ? '0 : frame_sum;
    clip_base = b1_fresh ? 1'b0 : sum_clipped;
    sum_wide  = {1'b0, sum_base} + (SUM_W + 1)'(b1_diff);
    if (sum_wide[SUM_W]) begin
      sum_new  = SUM_MAX;
      clip_new = 1'b1;
    end else begin
      sum_new  = sum_wide[SUM_W-1:0];
      clip_new = clip_base;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_sum   <= '0;
      sum_clipped <= 1'b0;
    end else if (advance && b1_valid) begin
      if (b1_last) begin
        frame_sum   <= '0;
        sum_clipped <= 1'b0;
      end else begin
        frame_sum   <= sum_new;
        sum_clipped <= clip_new;
      end
    end
  end

  // Output register: one transaction per finished frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= b1_valid && b1_last;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && b1_valid && b1_last) begin
      flux_value <= b1_warm ? '0 : sum_new;
      warming_up <= b1_warm;
      saturated  <= !b1_warm && clip_new;
    end
  end

endmodule

@@ rtl/core/spectral_difference_onset.sv @@
// Top level of the spectral difference onset detector: configuration registers,
// front end, queue and back end.
// Depends on sdo_pkg, sdo_front, sdo_queue and sdo_back.
//
//   Channel   Handshake              Payload
//   input     in_valid / in_stall    magnitude, include_req, last_bin, new_sequence
//   output    out_valid / out_stall  flux_value, warming_up, saturated
//   config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One bin is accepted per cycle unless in_stall is high; the history memory
// takes one read and one write per bin, and that single port pair sets the rate.
// Results pass front stage, queue, difference stage and output register in turn.
// Reset clears all control state; the history memory is not cleared.
// An output stall freezes the back end; the four-entry queue then fills and the
// input stalls once it can no longer absorb the bins in flight.
module spectral_difference_onset (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [sdo_pkg::MAG_W-1:0]      magnitude,
  input  logic                           include_req,
  input  logic                           last_bin,
  input  logic                           new_sequence,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [sdo_pkg::SUM_W-1:0]      flux_value,
  output logic                           warming_up,
  output logic                           saturated,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sdo_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sdo_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sdo_pkg::*;

  cfg_t                cfg;
  logic                push;
  entry_t              push_entry;
  logic                pop;
  entry_t              head_entry;
  logic                empty;
  logic [QLEVEL_W-1:0] queue_level;

  // Configuration registers take a write on every cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_frames   <= 3'd1;
      cfg.positive_only <= 1'b1;
      cfg.square_mode   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_STEP_FRAMES:   cfg.step_frames   <= cfg_data[2:0];
        REG_POSITIVE_ONLY: cfg.positive_only <= cfg_data[0];
        REG_SQUARE_MODE:   cfg.square_mode   <= cfg_data[0];
        default:           cfg               <= cfg;
      endcase
    end
  end

  sdo_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .magnitude    (magnitude),
    .include_req  (include_req),
    .last_bin     (last_bin),
    .new_sequence (new_sequence),
    .queue_level  (queue_level),
    .push         (push),
    .push_entry   (push_entry)
  );

  sdo_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head_entry (head_entry),
    .empty      (empty),
    .level      (queue_level)
  );

  sdo_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_entry (head_entry),
    .empty      (empty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .flux_value (flux_value),
    .warming_up (warming_up),
    .saturated  (saturated)
  );

endmodule

@@ tb/tb_spectral_difference_onset.sv @@
// Self-checking testbench for the spectral difference onset detector: streams bins
// with random idling and output stalls and checks every frame result in order.
// Depends on sdo_pkg and spectral_difference_onset.
module tb_spectral_difference_onset;
  timeunit 1ns;
  timeprecision 1ps;

  import sdo_pkg::*;

  localparam logic [63:0] SUM_CAP       = 64'hFFFF_FFFF_FFFF;
  localparam int          SETTLE_CYCLES = 12;
  localparam int          WATCH_LIMIT   = 2000;
  localparam int          PRINT_CAP     = 40;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             incl;
    logic             last;
    logic             fresh;
  } bin_t;

  typedef struct packed {
    logic [SUM_W-1:0] flux;
    logic             warm;
    logic             sat;
  } flux_result_t;

  // Clock, reset and block inputs, all known from time zero.
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [MAG_W-1:0]      magnitude = '0;
  logic                  include_req = 1'b0;
  logic                  last_bin = 1'b0;
  logic                  new_sequence = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [SUM_W-1:0]      flux_value;
  logic                  warming_up;
  logic                  saturated;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Flux model state: history ring, frame counters and the running sum.
  logic [MAG_W-1:0] hist_mem [HIST_DEPTH];
  bit               hist_written [HIST_DEPTH];
  int unsigned      pos_m, seen_m, slot_m;
  logic [63:0]      sum_m;
  bit               clip_m;
  cfg_t             model_cfg = '{step_frames: 3'd1, positive_only: 1'b1, square_mode: 1'b0};

  flux_result_t pending_flux [$];
  int           errors = 0;
  int           bins_sent = 0;
  int           frames_sent = 0;
  int           results_checked = 0;
  int           settings_done = 0;
  int           idle_cycles = 0;
  bit           idle_enable = 1'b1;
  bit           stall_enable = 1'b1;

  spectral_difference_onset dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .magnitude    (magnitude),
    .include_req  (include_req),
    .last_bin     (last_bin),
    .new_sequence (new_sequence),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .flux_value   (flux_value),
    .warming_up   (warming_up),
    .saturated    (saturated),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Free-running 2 ns clock.
  initial begin
    forever #1 clk = ~clk;
  end

  // Prints one line per mismatch up to a cap and counts every one.
  task automatic flag_mismatch(input string msg);
    errors++;
    if (errors <= PRINT_CAP) begin
      $display("MISMATCH: %s", msg);
    end
  endtask

  // Step distance in use: code zero acts as one, codes above the ring depth saturate.
  function automatic int unsigned eff_step();
    if (model_cfg.step_frames == 3'd0) return 1;
    if (model_cfg.step_frames > MAX_STEP) return MAX_STEP;
    return model_cfg.step_frames;
  endfunction

  // True if the bin after the one about to be sent would read only written history.
  function automatic bit history_ready(input bit fresh);
    int unsigned st, fs, sl, p, np;
    st = eff_step();
    fs = fresh ? 0 : seen_m;
    sl = fresh ? 0 : slot_m;
    p  = fresh ? 0 : pos_m;
    np = (p < NUM_BINS) ? p + 1 : p;
    if (fs < st || np >= NUM_BINS) return 1'b1;
    return hist_written[((sl + MAX_STEP - st) % MAX_STEP) * NUM_BINS + np];
  endfunction

  // Advances the flux model by one accepted bin and queues the frame result on the last bin.
  task automatic advance_flux_model(input bin_t b);
    int unsigned  st, old_a, new_a;
    logic [63:0]  d;
    logic [15:0]  prev;
    bit           warm;
    flux_result_t r;
    st = eff_step();
    if (b.fresh) begin
      pos_m  = 0;
      seen_m = 0;
      slot_m = 0;
      sum_m  = '0;
      clip_m = 1'b0;
    end
    warm = seen_m < st;
    // Bins past the frame size are neither stored nor summed.
    if (pos_m < NUM_BINS) begin
      old_a = ((slot_m + MAX_STEP - st) % MAX_STEP) * NUM_BINS + pos_m;
      new_a = slot_m * NUM_BINS + pos_m;
      prev  = hist_mem[old_a];
      if (b.incl && !warm) begin
        if (b.mag >= prev) begin
          d = 64'(b.mag) - 64'(prev);
        end else begin
          d = model_cfg.positive_only ? 64'd0 : 64'(prev) - 64'(b.mag);
        end
        if (model_cfg.square_mode) d = d * d;
        if (d > SUM_CAP - sum_m) begin
          sum_m  = SUM_CAP;
          clip_m = 1'b1;
        end else begin
          sum_m = sum_m + d;
        end
      end
      hist_mem[new_a]     = b.mag;
      hist_written[new_a] = 1'b1;
      pos_m++;
    end
    if (b.last) begin
      r.flux = warm ? '0 : sum_m[SUM_W-1:0];
      r.warm = warm;
      r.sat  = !warm && clip_m;
      pending_flux.push_back(r);
      frames_sent++;
      slot_m = (slot_m + 1) % MAX_STEP;
      if (seen_m < MAX_STEP) seen_m++;
      pos_m  = 0;
      sum_m  = '0;
      clip_m = 1'b0;
    end
  endtask

  // Sends one bin after an optional random gap and waits for its transaction.
  task automatic push_bin(input logic [MAG_W-1:0] mag, input bit incl, input bit last,
                          input bit fresh);
    int   gap;
    bin_t b;
    gap = 0;
    if (idle_enable) begin
      while ($urandom_range(99) < 31) gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    magnitude    <= mag;
    include_req  <= incl;
    last_bin     <= last;
    new_sequence <= fresh;
    do @(posedge clk); while (in_stall);
    b = '{mag: mag, incl: incl, last: last, fresh: fresh};
    advance_flux_model(b);
    bins_sent++;
  endtask

  // Stops the input and waits until every expected result has arrived and the pipe is empty.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_flux.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all three registers while the block is idle; spare data bits are randomized.
  task automatic program_detector(input logic [2:0] step, input bit pos_only, input bit square);
    cfg_reg_t   idx [3];
    logic [2:0] val [3];
    idx[0] = REG_STEP_FRAMES;
    val[0] = step;
    idx[1] = REG_POSITIVE_ONLY;
    val[1] = {2'($urandom_range(3)), pos_only};
    idx[2] = REG_SQUARE_MODE;
    val[2] = {2'($urandom_range(3)), square};
    settle();
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
      case (idx[i])
        REG_STEP_FRAMES:   model_cfg.step_frames   = val[i];
        REG_POSITIVE_ONLY: model_cfg.positive_only = val[i][0];
        REG_SQUARE_MODE:   model_cfg.square_mode   = val[i][0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
    settings_done++;
  endtask

  // Extreme magnitudes, rises, falls, equal values, excluded bins and a restart on a last bin.
  task automatic test_extremes();
    program_detector(3'd1, 1'b1, 1'b0);
    push_bin(16'd0, 1, 0, 1);
    push_bin(16'hFFFF, 1, 0, 0);
    push_bin(16'd12345, 0, 1, 0);
    push_bin(16'hFFFF, 1, 0, 0);
    push_bin(16'd0, 1, 0, 0);
    push_bin(16'd12345, 1, 1, 0);
    push_bin(16'd0, 0, 0, 0);
    push_bin(16'hFFFF, 1, 0, 0);
    push_bin(16'd12345, 1, 1, 0);
    // The excluded bin above must still have been stored.
    push_bin(16'd40000, 1, 0, 0);
    push_bin(16'd100, 1, 0, 0);
    push_bin(16'd7, 1, 1, 1);
    push_bin(16'd9, 1, 1, 0);
  endtask

  // Absolute differences of full scale, squared.
  task automatic test_absolute_squared();
    program_detector(3'd1, 1'b0, 1'b1);
    push_bin(16'd0, 1, 0, 1);
    push_bin(16'hFFFF, 1, 1, 0);
    push_bin(16'hFFFF, 1, 0, 0);
    push_bin(16'd0, 1, 1, 0);
    push_bin(16'hFFFF, 1, 1, 0);
  endtask

  // Deepest step: the old entry is read before the same slot is overwritten.
  task automatic test_ring_reuse();
    program_detector(3'd4, 1'b1, 1'b0);
    for (int f = 0; f < 6; f++) begin
      for (int k = 0; k < 2; k++) begin
        push_bin(16'($urandom), 1, k == 1, f == 0 && k == 0);
      end
    end
  endtask

  // One frame longer than the frame size, streamed with no idling on either side, then two
  // short frames. The last one reads the slot past the long frame, whose second entry was
  // last written by the ring reuse test, so a stray store of an excess bin shows up there.
  task automatic test_excess_bins();
    int flen [3];
    flen[0] = NUM_BINS + 2;
    flen[1] = 1;
    flen[2] = 2;
    program_detector(3'd1, 1'b0, 1'b0);
    idle_enable = 1'b0;
    stall_enable <= 1'b0;
    for (int f = 0; f < 3; f++) begin
      for (int k = 0; k < flen[f]; k++) begin
        push_bin(16'($urandom), $urandom_range(99) < 90, k == flen[f] - 1, f == 0 && k == 0);
      end
    end
    idle_enable = 1'b1;
    stall_enable <= 1'b1;
  endtask

  // Random frames under one setting; mostly well-formed, with stray restarts mid-frame.
  task automatic random_phase(input int n_items);
    int               sent, want, k;
    bit               fresh, last;
    logic [MAG_W-1:0] mag;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(99)) inside
        [0:69]:  want = $urandom_range(16, 1);
        [70:94]: want = $urandom_range(64, 17);
        default: want = $urandom_range(300, 65);
      endcase
      k = 0;
      last = 1'b0;
      while (!last) begin
        fresh = (k == 0 && (sent == 0 ? $urandom_range(1) == 1 : $urandom_range(99) < 8))
                || ($urandom_range(99) < 2);
        // Ending early keeps later bins away from history that was never written.
        last = (k + 1 >= want) || !history_ready(fresh);
        case ($urandom_range(9))
          0:       mag = '0;
          1:       mag = '1;
          2, 3:    mag = 16'($urandom_range(255));
          default: mag = 16'($urandom);
        endcase
        push_bin(mag, $urandom_range(99) < 85, last, fresh);
        sent++;
        k++;
      end
    end
  endtask

  // Several settings, including clamped step codes and both extremes.
  task automatic test_random_settings();
    logic [2:0] steps [10] = '{3'd1, 3'd2, 3'd3, 3'd4, 3'd0, 3'd7, 3'd5, 3'd6, 3'd4, 3'd1};
    bit         pos   [10] = '{1, 0, 1, 0, 1, 0, 1, 0, 1, 0};
    bit         sqr   [10] = '{0, 0, 1, 1, 0, 0, 1, 1, 0, 1};
    for (int i = 0; i < 10; i++) begin
      program_detector(steps[i], pos[i], sqr[i]);
      // One phase runs with no idling on either side.
      idle_enable = (i != 3);
      stall_enable <= (i != 3);
      random_phase(25);
    end
    idle_enable = 1'b1;
    stall_enable <= 1'b1;
  endtask

  // Output stall, random per cycle.
  always @(posedge clk) begin
    out_stall <= stall_enable && ($urandom_range(99) < 31);
  end

  // Compares each result transaction with the oldest expected frame result.
  always @(posedge clk) begin : check_result
    flux_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_flux.size() == 0) begin
        flag_mismatch($sformatf("unexpected result flux=%0d warm=%0b sat=%0b",
                                flux_value, warming_up, saturated));
      end else begin
        want = pending_flux.pop_front();
        results_checked++;
        if (flux_value !== want.flux)
          flag_mismatch($sformatf("result %0d flux_value %0d, expected %0d",
                                  results_checked, flux_value, want.flux));
        if (warming_up !== want.warm)
          flag_mismatch($sformatf("result %0d warming_up %0b, expected %0b",
                                  results_checked, warming_up, want.warm));
        if (saturated !== want.sat)
          flag_mismatch($sformatf("result %0d saturated %0b, expected %0b",
                                  results_checked, saturated, want.sat));
      end
    end
  end

  // Watchdog: too many cycles in a row with no transaction on any channel ends the run.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCH_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles", WATCH_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Test sequence.
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_extremes();
    test_absolute_squared();
    test_ring_reuse();
    test_excess_bins();
    test_random_settings();
    settle();
    if (pending_flux.size() != 0) begin
      flag_mismatch($sformatf("%0d expected results never arrived", pending_flux.size()));
    end
    $display("Run covered %0d bins in %0d frames with %0d results checked over %0d settings.",
             bins_sent, frames_sent, results_checked, settings_done);
    $display("Steps 1 to 4 incl. clamped codes, rectified and absolute, linear and squared.");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
